/* rtl/core/petr_pkg.sv */
// Package: shared types and constants for the PCR elapsed time tracker.
`timescale 1ns / 1ps

package petr_pkg;

    typedef enum logic [1:0] {
        OP_BYTE       = 2'd0,
        OP_FULL_RESET = 2'd1,
        OP_HALF_RESET = 2'd2,
        OP_NOP        = 2'd3
    } op_t;

    localparam logic [7:0]  SYNC_BYTE      = 8'h47;
    localparam logic [7:0]  AF_FLAG_MASK   = 8'h20;
    localparam logic [7:0]  PCR_FLAG_MASK  = 8'h10;
    localparam int unsigned PCR_DIVISOR    = 450;
    localparam logic [15:0] MAX_STEP_RESET = 16'd400;

    localparam logic [7:0]  POS_SYNC       = 8'd0;
    localparam logic [7:0]  POS_AF_CTRL    = 8'd3;
    localparam logic [7:0]  POS_AF_FLAGS   = 8'd5;
    localparam logic [7:0]  POS_PCR_FIRST  = 8'd6;
    localparam logic [7:0]  POS_PCR_MID0   = 8'd7;
    localparam logic [7:0]  POS_PCR_MID1   = 8'd8;
    localparam logic [7:0]  POS_PCR_LAST   = 8'd9;

    // Clock event handed from the framer to the tracker
    typedef struct packed {
        logic        apply;
        logic [23:0] clock;
    } clk_evt_t;

    // Next result values produced by the tracker
    typedef struct packed {
        logic [31:0] elapsed;
        logic        taken;
        logic        pending;
    } trk_res_t;

    typedef struct packed {
        logic [7:0] digit;
        logic [8:0] rem;
    } div_step_t;

    // One byte of long division by the PCR divisor: n = {remainder, byte}
    function automatic div_step_t div_digit(input logic [16:0] n);
        logic [16:0] r;
        logic [16:0] d;
        div_step_t   res;
        r = n;
        res.digit = 8'd0;
        for (int i = 7; i >= 0; i--)
        begin
            d = 17'(PCR_DIVISOR) << i;
            if (r >= d)
            begin
                r = r - d;
                res.digit[i] = 1'b1;
            end
        end
        res.rem = r[8:0];
        return res;
    endfunction

endpackage

/* rtl/core/pcr_elapsed_time_tracker.sv */
// Top level: PCR elapsed time tracker with input and result registers.
// Each item is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the input register advances whenever the
//   result register is empty or its result transfers in the same cycle.
// The PCR word is divided by 450 one byte per cycle while bytes 6 to 9 advance.
// Reset (rst_n low, asynchronous): empty pipeline, tracker cleared, max_step 400.
`timescale 1ns / 1ps

module pcr_elapsed_time_tracker
    import petr_pkg::*;
#(
    parameter int PACKET_BYTES = 188
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] elapsed_time,
    output logic        pcr_taken,
    output logic        jump_pending,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    // Input register stage
    logic       s1_valid_reg;
    op_t        s1_op_reg;
    logic [7:0] s1_byte_reg;

    // Result register stage
    logic        out_valid_reg;
    logic [31:0] elapsed_reg;
    logic        taken_reg;
    logic        pending_reg;

    logic [15:0] max_step_reg;

    logic     advance;
    clk_evt_t evt;
    trk_res_t res;

    // Advance the held item when the result register is free or draining now
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;

    // Hold the configured step limit; the user must make writes only while idle, unenforced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_step_reg <= MAX_STEP_RESET;
        else if (cfg_wr_en)
            max_step_reg <= cfg_wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg   <= op_t'(op);
            s1_byte_reg <= data_byte;
        end
    end

    petr_framer #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_framer (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .op        (s1_op_reg),
        .data_byte (s1_byte_reg),
        .evt       (evt)
    );

    petr_tracker u_tracker (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .op       (s1_op_reg),
        .evt      (evt),
        .max_step (max_step_reg),
        .res      (res)
    );

    // Capture the result on advance; drop valid once it transfers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            elapsed_reg <= res.elapsed;
            taken_reg   <= res.taken;
            pending_reg <= res.pending;
        end
    end

    assign out_valid    = out_valid_reg;
    assign elapsed_time = elapsed_reg;
    assign pcr_taken    = taken_reg;
    assign jump_pending = pending_reg;

endmodule

/* rtl/core/petr_framer.sv */
// Framer: packet position, PCR flag checks and byte-wise division of the PCR word.
`timescale 1ns / 1ps

module petr_framer
    import petr_pkg::*;
#(
    parameter int PACKET_BYTES = 188
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  op_t        op,
    input  logic [7:0] data_byte,
    output clk_evt_t   evt
);

    localparam logic [7:0] LAST_POS = 8'(PACKET_BYTES - 1);

    logic [7:0]  pos_reg, pos_next;
    logic        has_pcr_reg, has_pcr_next;
    logic        nonzero_reg, nonzero_next;
    logic [8:0]  rem_reg, rem_next;
    logic [23:0] quo_reg, quo_next;
    logic [16:0] div_in;
    div_step_t   step;
    logic        byte_nz;
    logic        last_byte;

    assign byte_nz   = |data_byte;
    assign last_byte = (pos_reg >= LAST_POS);
    assign div_in    = (pos_reg == POS_PCR_FIRST) ? {9'd0, data_byte} : {rem_reg, data_byte};
    assign step      = div_digit(div_in);

    always_comb
    begin
        pos_next     = pos_reg;
        has_pcr_next = has_pcr_reg;
        nonzero_next = nonzero_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        if (op == OP_FULL_RESET || op == OP_HALF_RESET)
        begin
            pos_next     = 8'd0;
            has_pcr_next = 1'b0;
        end
        else if (op == OP_BYTE)
        begin
            case (pos_reg)
                POS_SYNC:
                begin
                    has_pcr_next = (data_byte == SYNC_BYTE);
                end
                POS_AF_CTRL:
                begin
                    if ((data_byte & AF_FLAG_MASK) == 8'd0)
                        has_pcr_next = 1'b0;
                end
                POS_AF_FLAGS:
                begin
                    if ((data_byte & PCR_FLAG_MASK) == 8'd0)
                        has_pcr_next = 1'b0;
                end
                POS_PCR_FIRST:
                begin
                    nonzero_next = byte_nz;
                    rem_next     = step.rem;
                    quo_next     = {16'd0, step.digit};
                end
                POS_PCR_MID0, POS_PCR_MID1:
                begin
                    nonzero_next = nonzero_reg | byte_nz;
                    rem_next     = step.rem;
                    quo_next     = {quo_reg[15:0], step.digit};
                end
                POS_PCR_LAST:
                begin
                    // drop the PCR when the whole word is zero
                    if (!(nonzero_reg | byte_nz))
                        has_pcr_next = 1'b0;
                    rem_next = step.rem;
                    quo_next = {quo_reg[15:0], step.digit};
                end
                default:
                begin
                end
            endcase
            if (last_byte)
            begin
                has_pcr_next = 1'b0;
                pos_next     = 8'd0;
            end
            else
            begin
                pos_next = pos_reg + 8'd1;
            end
        end
    end

    assign evt.apply = (op == OP_BYTE) && last_byte && has_pcr_reg;
    assign evt.clock = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 8'd0;
            has_pcr_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg     <= pos_next;
            has_pcr_reg <= has_pcr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            nonzero_reg <= nonzero_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
        end
    end

endmodule

/* rtl/core/petr_tracker.sv */
// Tracker: clock continuity, jump confirmation and elapsed time accumulation.
`timescale 1ns / 1ps

module petr_tracker
    import petr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  op_t         op,
    input  clk_evt_t    evt,
    input  logic [15:0] max_step,
    output trk_res_t    res
);

    logic [23:0] last_reg, last_next;
    logic        base_valid_reg, base_valid_next;
    logic [23:0] pending_reg, pending_next;
    logic [15:0] step_reg, step_next;
    logic [31:0] elapsed_reg, elapsed_next;

    logic [23:0] delta;
    logic [24:0] last_limit;
    logic [24:0] pend_limit;
    logic        is_jump;
    logic        confirm;

    assign delta      = evt.clock - last_reg;
    assign last_limit = {1'b0, last_reg} + {9'd0, max_step};
    assign pend_limit = {1'b0, pending_reg} + {9'd0, max_step};
    assign is_jump    = (evt.clock < last_reg) || ({1'b0, evt.clock} > last_limit);
    assign confirm    = (pending_reg != 24'd0) && (evt.clock >= pending_reg)
                        && ({1'b0, evt.clock} < pend_limit);

    always_comb
    begin
        last_next       = last_reg;
        base_valid_next = base_valid_reg;
        pending_next    = pending_reg;
        step_next       = step_reg;
        elapsed_next    = elapsed_reg;
        case (op)
            OP_FULL_RESET:
            begin
                last_next       = 24'd0;
                base_valid_next = 1'b0;
                pending_next    = 24'd0;
                step_next       = 16'd0;
                elapsed_next    = 32'd0;
            end
            OP_HALF_RESET:
            begin
                base_valid_next = (last_reg != 24'd0);
                pending_next    = 24'd0;
                step_next       = 16'd0;
                elapsed_next    = 32'd0;
            end
            OP_BYTE:
            begin
                if (evt.apply)
                begin
                    if (!base_valid_reg)
                    begin
                        // base and last move together, elapsed holds
                        base_valid_next = (evt.clock != 24'd0);
                        last_next       = evt.clock;
                        step_next       = 16'd0;
                    end
                    else if (evt.clock == last_reg)
                    begin
                    end
                    else if (is_jump)
                    begin
                        if (confirm)
                        begin
                            elapsed_next = elapsed_reg + {15'd0, step_reg, 1'b0};
                            last_next    = evt.clock;
                            pending_next = 24'd0;
                        end
                        else
                        begin
                            pending_next = evt.clock;
                        end
                    end
                    else
                    begin
                        pending_next = 24'd0;
                        step_next    = delta[15:0];
                        last_next    = evt.clock;
                        elapsed_next = elapsed_reg + {8'd0, delta};
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign res.elapsed = elapsed_next;
    assign res.taken   = (op == OP_BYTE) && evt.apply;
    assign res.pending = (pending_next != 24'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= 24'd0;
            base_valid_reg <= 1'b0;
            pending_reg    <= 24'd0;
            step_reg       <= 16'd0;
            elapsed_reg    <= 32'd0;
        end
        else if (advance)
        begin
            last_reg       <= last_next;
            base_valid_reg <= base_valid_next;
            pending_reg    <= pending_next;
            step_reg       <= step_next;
            elapsed_reg    <= elapsed_next;
        end
    end

endmodule

/* dv/tb_pcr_elapsed_time_tracker.sv */
// Testbench for the PCR elapsed time tracker: directed packet table, random stream, scoreboard.
`timescale 1ns / 1ps

module tb_pcr_elapsed_time_tracker;
    import petr_pkg::*;

    localparam int          PACKET_BYTES      = 188;
    // Largest clock whose PCR word still fits in 32 bits
    localparam int unsigned CLOCK_MAX         = 32'hFFFF_FFFF / PCR_DIVISOR;
    localparam int          HOLD_OFF_CYCLES   = 300;
    localparam int          IDLE_LIMIT        = 2000;
    localparam int          PACKETS_PER_PHASE = 1;
    localparam int          CFG_SETTLE        = 4;
    localparam int          DRAIN_CYCLES      = 8;

    // One result as the block should present it
    typedef struct packed {
        logic [31:0] elapsed;
        logic        taken;
        logic        pending;
    } elapsed_res_t;

    typedef enum logic [1:0] {
        ROW_OP,
        ROW_PKT,
        ROW_CFG
    } row_kind_e;

    // One line of the directed table: a lone op, a whole packet, or a max_step write
    typedef struct packed {
        row_kind_e    kind;
        op_t          op;
        logic [15:0]  cfg;
        logic [7:0]   sync;
        logic [7:0]   af;
        logic [7:0]   flags;
        logic [31:0]  word;
        logic         fixed;
        elapsed_res_t res;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    op_t         op;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] elapsed_time;
    logic        pcr_taken;
    logic        jump_pending;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    pcr_elapsed_time_tracker #(
        .PACKET_BYTES (PACKET_BYTES)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .elapsed_time (elapsed_time),
        .pcr_taken    (pcr_taken),
        .jump_pending (jump_pending),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Results still owed by the block, oldest first
    elapsed_res_t tracker_results_q[$];

    int fail_count     = 0;
    int idle_cycles    = 0;
    int n_transfers    = 0;
    int n_taken        = 0;
    int n_confirmed    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_off_req   = 1'b0;

    // Tracker state as the testbench expects it to evolve
    logic [7:0]  trk_pos;
    logic        trk_has_pcr;
    logic [23:0] trk_shift;
    logic [23:0] trk_last;
    logic [23:0] trk_base;
    logic [23:0] trk_pend;
    logic [15:0] trk_step;
    logic [31:0] trk_accum;
    logic [15:0] trk_max_step;

    task automatic clear_tracker_state();
        trk_pos     = '0;
        trk_has_pcr = 1'b0;
        trk_shift   = '0;
        trk_last    = '0;
        trk_base    = '0;
        trk_pend    = '0;
        trk_step    = '0;
        trk_accum   = '0;
    endtask

    // Apply one PCR clock with the jump rule: a jump waits for a second,
    // nearby clock before the finished segment is folded into the total.
    task automatic advance_clock(input logic [23:0] c);
        logic [31:0] last_lim;
        logic [31:0] pend_lim;
        last_lim = 32'(trk_last) + 32'(trk_max_step);
        pend_lim = 32'(trk_pend) + 32'(trk_max_step);
        if (trk_base == 24'd0)
        begin
            trk_base = c;
            trk_step = '0;
            trk_last = c;
        end
        else if (c != trk_last)
        begin
            if (c < trk_last || 32'(c) > last_lim)
            begin
                if (trk_pend != 24'd0 && c >= trk_pend && 32'(c) < pend_lim)
                begin
                    trk_accum = trk_accum + (32'(trk_last) - 32'(trk_base))
                                + 32'(trk_step) * 32'd2;
                    trk_base  = c;
                    trk_last  = c;
                    trk_pend  = '0;
                    n_confirmed++;
                end
                else
                    trk_pend = c;
            end
            else
            begin
                trk_pend = '0;
                trk_step = 16'(c - trk_last);
                trk_last = c;
            end
        end
    endtask

    // Advance the expected state by one accepted transfer and form its result
    task automatic track_byte(input op_t cmd, input logic [7:0] b, output elapsed_res_t r);
        logic [23:0] keep;
        logic [31:0] word;
        logic [7:0]  p;
        r.taken = 1'b0;
        case (cmd)
            OP_FULL_RESET:
                clear_tracker_state();
            OP_HALF_RESET:
            begin
                keep = trk_last;
                clear_tracker_state();
                trk_last = keep;
                trk_base = keep;
            end
            OP_BYTE:
            begin
                p = trk_pos;
                if (p == POS_SYNC)
                    trk_has_pcr = (b == SYNC_BYTE);
                else if (p == POS_AF_CTRL)
                begin
                    if ((b & AF_FLAG_MASK) == 8'd0)
                        trk_has_pcr = 1'b0;
                end
                else if (p == POS_AF_FLAGS)
                begin
                    if ((b & PCR_FLAG_MASK) == 8'd0)
                        trk_has_pcr = 1'b0;
                end
                else if (p == POS_PCR_FIRST)
                    trk_shift = 24'(b);
                else if (p == POS_PCR_MID0 || p == POS_PCR_MID1)
                    trk_shift = {trk_shift[15:0], b};
                else if (p == POS_PCR_LAST)
                begin
                    word = {trk_shift, b};
                    if (word == 32'd0)
                        trk_has_pcr = 1'b0;
                    trk_shift = 24'(word / PCR_DIVISOR);
                end
                if (int'(p) >= PACKET_BYTES - 1)
                begin
                    if (trk_has_pcr)
                    begin
                        advance_clock(trk_shift);
                        r.taken = 1'b1;
                        n_taken++;
                    end
                    trk_has_pcr = 1'b0;
                    trk_pos     = '0;
                end
                else
                    trk_pos = p + 8'd1;
            end
            default:
                ;
        endcase
        r.elapsed = trk_accum + 32'(trk_last) - 32'(trk_base);
        r.pending = (trk_pend != 24'd0);
    endtask

    // Offer one transfer; idle first at the current sender rate. Valid stays
    // high across back-to-back items and drops only when a gap is taken.
    task automatic send_item(input op_t cmd, input logic [7:0] b, input bit fixed,
                             input elapsed_res_t fixed_res);
        elapsed_res_t r;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid  = 1'b1;
        op        = cmd;
        data_byte = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        // Push at the falling edge so the scoreboard never pops in the same step
        track_byte(cmd, b, r);
        tracker_results_q.push_back(fixed ? fixed_res : r);
        n_transfers++;
    endtask

    // Hold valid low and let the block drain before touching max_step
    task automatic wait_idle();
        in_valid = 1'b0;
        while (tracker_results_q.size() != 0)
            @(negedge clk);
        repeat (CFG_SETTLE) @(negedge clk);
    endtask

    task automatic write_max_step(input logic [15:0] value);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en    = 1'b0;
        trk_max_step = value;
    endtask

    // PCR word that decodes to clock c, with a remainder that the divide drops
    function automatic logic [31:0] clock_word(input int unsigned c, input int unsigned rem);
        return 32'(c * PCR_DIVISOR + rem);
    endfunction

    // Byte k of a packet: header and PCR bytes as given, payload random
    function automatic logic [7:0] packet_byte(input int k, input logic [7:0] sync,
                                               input logic [7:0] af, input logic [7:0] flags,
                                               input logic [31:0] word);
        case (k)
            POS_SYNC:      return sync;
            POS_AF_CTRL:   return af;
            POS_AF_FLAGS:  return flags;
            POS_PCR_FIRST: return word[31:24];
            POS_PCR_MID0:  return word[23:16];
            POS_PCR_MID1:  return word[15:8];
            POS_PCR_LAST:  return word[7:0];
            default:       return 8'($urandom);
        endcase
    endfunction

    function automatic row_t op_row(input op_t cmd, input bit fixed, input elapsed_res_t res);
        row_t r;
        r       = '0;
        r.kind  = ROW_OP;
        r.op    = cmd;
        r.fixed = fixed;
        r.res   = res;
        return r;
    endfunction

    function automatic row_t pkt_row(input logic [7:0] sync, input logic [7:0] af,
                                     input logic [7:0] flags, input logic [31:0] word,
                                     input bit fixed, input elapsed_res_t res);
        row_t r;
        r       = '0;
        r.kind  = ROW_PKT;
        r.op    = OP_BYTE;
        r.sync  = sync;
        r.af    = af;
        r.flags = flags;
        r.word  = word;
        r.fixed = fixed;
        r.res   = res;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [15:0] value);
        row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.cfg  = value;
        return r;
    endfunction

    // Result side: random stalls at the phase rate, plus one long hold-off on
    // request that backs the block up until it stops taking input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Scoreboard: compare each result transfer with the oldest expectation;
    // count cycles with no transfer on either side for the watchdog.
    initial
    begin
        elapsed_res_t want;
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (out_valid && out_ready)
            begin
                if (tracker_results_q.size() == 0)
                begin
                    $error("unexpected result: elapsed_time %0d pcr_taken %0b jump_pending %0b",
                           elapsed_time, pcr_taken, jump_pending);
                    fail_count++;
                end
                else
                begin
                    want = tracker_results_q.pop_front();
                    if (elapsed_time !== want.elapsed)
                    begin
                        $error("elapsed_time: expected %0d, got %0d", want.elapsed, elapsed_time);
                        fail_count++;
                    end
                    if (pcr_taken !== want.taken)
                    begin
                        $error("pcr_taken: expected %0b, got %0b", want.taken, pcr_taken);
                        fail_count++;
                    end
                    if (jump_pending !== want.pending)
                    begin
                        $error("jump_pending: expected %0b, got %0b", want.pending, jump_pending);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog: end the run once nothing has moved for too long
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $error("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, tracker_results_q.size());
        $display("** pcr_elapsed_time_tracker: FAILED **");
        $finish;
    end

    initial
    begin
        row_t            rows[$];
        elapsed_res_t    none;
        op_t             noise;
        logic [7:0]      hdr_sync;
        logic [7:0]      hdr_af;
        logic [7:0]      hdr_flags;
        logic [31:0]     word;
        longint unsigned c;
        longint unsigned w;
        int unsigned     sel;
        int unsigned     ms;
        bit              aborted;
        logic [15:0]     phase_step[4];
        int              send_pct[4];
        int              recv_pct[4];

        // Drive every input to a known value before reset releases
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_NOP;
        data_byte   = 8'd0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 16'd0;
        none        = '0;
        trk_max_step = MAX_STEP_RESET;
        clear_tracker_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table. Fixed results are typed in only where obvious; every
        // other row is checked against the expected-state tracker.
        rows.push_back(op_row(OP_NOP, 1'b1, elapsed_res_t'{32'd0, 1'b0, 1'b0}));
        // first clock sets the base
        rows.push_back(pkt_row(SYNC_BYTE, AF_FLAG_MASK, PCR_FLAG_MASK, clock_word(1000, 0),
                               1'b1, elapsed_res_t'{32'd0, 1'b1, 1'b0}));
        // step of exactly max_step is still continuous; the remainder is dropped
        rows.push_back(pkt_row(8'h47, 8'hFF, 8'hFF, clock_word(1400, 449), 1'b0, none));
        // one past it is a jump, then confirm just inside the window
        rows.push_back(pkt_row(8'h47, 8'h20, 8'h10, clock_word(1801, 0), 1'b0, none));
        rows.push_back(pkt_row(8'h47, 8'h20, 8'h10, clock_word(2200, 0), 1'b0, none));
        rows.push_back(op_row(OP_HALF_RESET, 1'b1, elapsed_res_t'{32'd0, 1'b0, 1'b0}));
        rows.push_back(op_row(OP_FULL_RESET, 1'b1, elapsed_res_t'{32'd0, 1'b0, 1'b0}));
        // max_step of zero; a small word gives clock zero, which still counts as applied
        rows.push_back(cfg_row(16'd0));
        rows.push_back(pkt_row(8'h47, 8'h20, 8'h10, 32'd449,
                               1'b1, elapsed_res_t'{32'd0, 1'b1, 1'b0}));

        foreach (rows[i])
        begin
            case (rows[i].kind)
                ROW_CFG:
                begin
                    wait_idle();
                    write_max_step(rows[i].cfg);
                end
                ROW_OP:
                    send_item(rows[i].op, 8'($urandom), rows[i].fixed, rows[i].res);
                default:
                    for (int k = 0; k < PACKET_BYTES; k++)
                        send_item(OP_BYTE,
                                  packet_byte(k, rows[i].sync, rows[i].af, rows[i].flags,
                                              rows[i].word),
                                  rows[i].fixed && (k == PACKET_BYTES - 1), rows[i].res);
            endcase
        end

        // Random phases: no idling with a long result hold-off, sender idle,
        // receiver stalling, then both sides idling lightly.
        phase_step[0] = MAX_STEP_RESET;
        phase_step[1] = 16'hFFFF;
        phase_step[2] = 16'd0;
        phase_step[3] = 16'($urandom_range(2, 3000));
        send_pct[0] = 0;
        recv_pct[0] = 0;
        send_pct[1] = 85;
        recv_pct[1] = 0;
        send_pct[2] = 0;
        recv_pct[2] = 85;
        send_pct[3] = 20;
        recv_pct[3] = 20;

        for (int ph = 0; ph < 4; ph++)
        begin
            wait_idle();
            write_max_step(phase_step[ph]);
            send_idle_pct  = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            if (ph == 0)
                hold_off_req = 1'b1;
            for (int n = 0; n < PACKETS_PER_PHASE; n++)
            begin
                // Pick the next clock relative to the tracked state so that
                // continuous steps, jumps and confirmations all come up.
                ms  = trk_max_step;
                sel = $urandom_range(0, 99);
                c   = $urandom_range(1, CLOCK_MAX);
                if (sel < 35)
                    c = trk_last + $urandom_range(1, (ms == 0) ? 1 : ms);
                else if (sel < 45)
                    c = trk_last;
                else if (sel >= 65 && sel < 80 && trk_pend != 24'd0 && ms != 0)
                    c = trk_pend + $urandom_range(0, ms - 1);
                else if (sel >= 80 && sel < 85)
                    c = (trk_pend != 24'd0) ? trk_pend + ms : trk_last + ms + 1;
                else if (sel >= 95 && trk_last != 24'd0)
                    c = trk_last - $urandom_range(1, trk_last);
                if (c > CLOCK_MAX)
                    c = CLOCK_MAX;
                w = c * PCR_DIVISOR + $urandom_range(0, PCR_DIVISOR - 1);
                if (w > 64'hFFFF_FFFF)
                    w = 64'hFFFF_FFFF;
                word = 32'(w);
                if (sel >= 85 && sel < 90)
                    word = 32'd0;
                else if (sel >= 90 && sel < 95)
                    word = 32'($urandom_range(1, PCR_DIVISOR - 1));

                // Mostly well-formed headers; break one field now and then
                hdr_sync  = SYNC_BYTE;
                hdr_af    = 8'($urandom) | AF_FLAG_MASK;
                hdr_flags = 8'($urandom) | PCR_FLAG_MASK;
                sel = $urandom_range(0, 99);
                if (sel < 4)
                    hdr_sync = 8'($urandom);
                else if (sel < 8)
                    hdr_af = 8'($urandom) & ~AF_FLAG_MASK;
                else if (sel < 12)
                    hdr_flags = 8'($urandom) & ~PCR_FLAG_MASK;

                // Drop the rest of the packet if a reset restarts the framing
                aborted = 1'b0;
                for (int k = 0; k < PACKET_BYTES && !aborted; k++)
                begin
                    if ($urandom_range(0, 249) == 0)
                    begin
                        noise = op_t'($urandom_range(1, 3));
                        send_item(noise, 8'($urandom), 1'b0, none);
                        aborted = (noise != OP_NOP);
                    end
                    if (!aborted)
                        send_item(OP_BYTE, packet_byte(k, hdr_sync, hdr_af, hdr_flags, word),
                                  1'b0, none);
                end
            end
        end

        // Drain: wait for every owed result, then keep watching for strays
        in_valid = 1'b0;
        while (tracker_results_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d transfers, %0d PCR clocks applied, %0d jumps confirmed.",
                 n_transfers, n_taken, n_confirmed);
        $display("max_step from 0 to 65535, four flow-control phases, one long hold-off.");
        if (fail_count == 0)
            $display("** pcr_elapsed_time_tracker: PASSED **");
        else
            $display("** pcr_elapsed_time_tracker: FAILED **");
        $finish;
    end

endmodule
